// ----- rtl/core/valve_position_reply_parser_core_macros.svh -----
// Assertion macros shared by the valve position reply parser RTL.
`ifndef VALVE_POSITION_REPLY_PARSER_CORE_MACROS_SVH
`define VALVE_POSITION_REPLY_PARSER_CORE_MACROS_SVH

// Checks an implication or sequence property on the rising clock edge, skipped in reset.
`define VPR_ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds on the rising clock edge, skipped in reset.
`define VPR_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- rtl/core/vpr_pkg.sv -----
// Package with the types and character constants of the valve position reply parser.
package vpr_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VTYPE_W = 4;
   localparam int unsigned INDEX_W = 5;

   localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_UP_C  = 8'h43;
   localparam logic [BYTE_W-1:0] CHAR_UP_P  = 8'h50;
   localparam logic [BYTE_W-1:0] CHAR_LO_O  = 8'h6F;
   localparam logic [BYTE_W-1:0] CHAR_LO_S  = 8'h73;
   localparam logic [BYTE_W-1:0] CHAR_LO_I  = 8'h69;
   localparam logic [BYTE_W-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UP_B  = 8'h42;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic FORMAT_CP  = 1'b0;
   localparam logic FORMAT_POS = 1'b1;

   localparam logic CSR_VALVE_TYPE   = 1'b0;
   localparam logic CSR_REPLY_FORMAT = 1'b1;

   typedef struct packed {
      logic [VTYPE_W-1:0] valve_type;
      logic               reply_format;
   } vpr_cfg_type;

   typedef struct packed {
      logic              hit;
      logic [BYTE_W-1:0] value;
   } vpr_result_type;

endpackage

// ----- rtl/core/vpr_match.sv -----
// Reply matcher: match position, saved tens digit and the per-byte decode.
module vpr_match
   import vpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [BYTE_W-1:0]  rx_byte,
   input  vpr_cfg_type        cfg,
   output vpr_result_type     result
);

   localparam logic [INDEX_W-1:0] IDX_START = 5'd0;
   localparam logic [INDEX_W-1:0] IDX_ADDR  = 5'd1;
   localparam logic [INDEX_W-1:0] IDX_TWO   = 5'd2;
   localparam logic [INDEX_W-1:0] IDX_THREE = 5'd3;
   localparam logic [INDEX_W-1:0] IDX_FOUR  = 5'd4;
   localparam logic [INDEX_W-1:0] IDX_FIVE  = 5'd5;
   localparam logic [INDEX_W-1:0] IDX_SIX   = 5'd6;
   localparam logic [INDEX_W-1:0] IDX_ELVN  = 5'd11;
   localparam logic [INDEX_W-1:0] IDX_TWLV  = 5'd12;
   localparam logic [INDEX_W-1:0] IDX_THRT  = 5'd13;
   localparam logic [INDEX_W-1:0] IDX_FRTN  = 5'd14;
   localparam logic [INDEX_W-1:0] IDX_FFTN  = 5'd15;
   localparam logic [INDEX_W-1:0] IDX_LAST  = 5'd16;

   logic [INDEX_W-1:0] match_index_ff, match_index_in;
   logic [BYTE_W-1:0]  tens_digit_ff, tens_digit_in;

   logic [BYTE_W-1:0]  addr_char;
   logic               is_digit;
   logic [BYTE_W-1:0]  tens_off;
   logic [BYTE_W-1:0]  units_off;
   logic [BYTE_W-1:0]  cp_value;

   assign addr_char = CHAR_ZERO + {{(BYTE_W-VTYPE_W){1'b0}}, cfg.valve_type};
   assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign tens_off  = tens_digit_ff - CHAR_ZERO;
   assign units_off = rx_byte - CHAR_ZERO;
   // Times ten as eight plus two, kept modulo 256.
   assign cp_value  = {tens_off[BYTE_W-4:0], 3'b000} + {tens_off[BYTE_W-2:0], 1'b0} + units_off;

   always_comb begin
      match_index_in = IDX_START;
      tens_digit_in  = tens_digit_ff;
      result.hit     = 1'b0;
      result.value   = rx_byte;
      if (cfg.reply_format == FORMAT_CP) begin
         unique case (match_index_ff)
            IDX_START: match_index_in = (rx_byte == CHAR_SLASH) ? IDX_ADDR : IDX_START;
            IDX_ADDR:  match_index_in = (rx_byte == addr_char) ? IDX_TWO : IDX_START;
            IDX_TWO:   match_index_in = (rx_byte == CHAR_UP_C) ? IDX_THREE : IDX_START;
            IDX_THREE: match_index_in = (rx_byte == CHAR_UP_P) ? IDX_FOUR : IDX_START;
            IDX_FOUR: begin
               if (is_digit) begin
                  tens_digit_in  = rx_byte;
                  match_index_in = IDX_FIVE;
               end
            end
            IDX_FIVE: begin
               result.hit   = is_digit;
               result.value = cp_value;
            end
            default: match_index_in = IDX_START;
         endcase
      end else begin
         unique case (match_index_ff) inside
            IDX_START: match_index_in = (rx_byte == CHAR_SLASH) ? IDX_ADDR : IDX_START;
            IDX_ADDR:  match_index_in = (rx_byte == addr_char) ? IDX_TWO : IDX_START;
            IDX_THREE: match_index_in = (rx_byte == CHAR_UP_P) ? IDX_FOUR : IDX_START;
            IDX_FOUR:  match_index_in = (rx_byte == CHAR_LO_O) ? IDX_FIVE : IDX_START;
            IDX_FIVE:  match_index_in = (rx_byte == CHAR_LO_S) ? IDX_SIX : IDX_START;
            IDX_TWLV:  match_index_in = (rx_byte == CHAR_LO_I) ? IDX_THRT : IDX_START;
            IDX_THRT:  match_index_in = (rx_byte == CHAR_LO_S) ? IDX_FRTN : IDX_START;
            IDX_TWO, [IDX_SIX:IDX_ELVN], IDX_FRTN, IDX_FFTN:
               match_index_in = match_index_ff + 5'd1;
            IDX_LAST:  result.hit = (rx_byte == CHAR_UP_A) || (rx_byte == CHAR_UP_B);
            default:   match_index_in = IDX_START;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_index_ff <= IDX_START;
         tens_digit_ff  <= '0;
      end else if (advance) begin
         match_index_ff <= match_index_in;
         tens_digit_ff  <= tens_digit_in;
      end
   end

endmodule

// ----- rtl/core/valve_position_reply_parser_core.sv -----
// A request that completes a reply leaves its value in the result register, flagged by
// rsp_valid. Throughput: one request per cycle while the result is not stalled; the only
// feedback is the match state update. A request is held in the input register while the
// result register is full and stalled. Reset (synchronous, active high) clears both valid
// flags, the match position, the saved tens digit and the configuration registers.
module valve_position_reply_parser_core
   import vpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_position_value,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [VTYPE_W-1:0] csr_write_data
);

`include "valve_position_reply_parser_core_macros.svh"

   logic               s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]  s1_byte_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_value_ff;
   vpr_cfg_type        cfg_ff;
   logic               advance;
   logic               req_take;
   vpr_result_type     match_result;

   // The input register moves on when the result register is empty or being drained.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = (advance && match_result.hit) || (rsp_valid_ff && rsp_stall);

   vpr_match u_match (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (s1_byte_ff),
      .cfg     (cfg_ff),
      .result  (match_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_rx_byte;
      end
      if (advance && match_result.hit) begin
         rsp_value_ff <= match_result.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.valve_type   <= '0;
         cfg_ff.reply_format <= FORMAT_CP;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VALVE_TYPE:   cfg_ff.valve_type   <= csr_write_data;
            CSR_REPLY_FORMAT: cfg_ff.reply_format <= csr_write_data[0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_value = rsp_value_ff;

   `VPR_ASSERT_PROP(a_hold_input, clock, reset, (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_byte_ff)), "blocked request lost from input register")
   `VPR_ASSERT_PROP(a_rise_from_advance, clock, reset, $rose(rsp_valid_ff) |-> $past(advance), "result appeared without a processed request")
   `VPR_ASSERT_PROP(a_hit_delivered, clock, reset, (advance && match_result.hit) |=> rsp_valid_ff, "completed reply did not reach the result register")
   `VPR_ASSERT_NEVER(a_no_overwrite, clock, reset, advance && rsp_valid_ff && rsp_stall, "pending result overwritten")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the valve position reply parser core.
module tb_top;
   import vpr_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_BYTES  = 80;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_rx_byte        = '0;
   logic               rsp_valid;
   logic               rsp_stall          = 1'b0;
   logic [BYTE_W-1:0]  rsp_position_value;
   logic               csr_write_enable   = 1'b0;
   logic               csr_index          = CSR_VALVE_TYPE;
   logic [VTYPE_W-1:0] csr_write_data     = '0;

   logic [BYTE_W-1:0]  rx_byte_queue[$];
   logic [BYTE_W-1:0]  expected_positions[$];
   int                 error_count = 0;

   // Shadow of the parser state and its registers.
   logic [INDEX_W-1:0] match_idx;
   logic [BYTE_W-1:0]  tens_char;
   logic [VTYPE_W-1:0] cfg_vtype;
   logic               cfg_format;

   int burst_left = 0;
   int gap_left   = 0;
   int stall_mode = 0;
   int mode_left  = 0;
   int stall_tick = 0;
   int idle_cycles = 0;

   valve_position_reply_parser_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position_value (rsp_position_value),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic logic predict_position(input logic [BYTE_W-1:0] b,
                                             output logic [BYTE_W-1:0] pos);
      logic hit;
      hit = 1'b0;
      pos = '0;
      if (cfg_format == FORMAT_CP) begin
         case (match_idx)
            0: if (b == CHAR_SLASH) match_idx = 1;
            1: match_idx = (b == CHAR_ZERO + cfg_vtype) ? 2 : 0;
            2: match_idx = (b == CHAR_UP_C) ? 3 : 0;
            3: match_idx = (b == CHAR_UP_P) ? 4 : 0;
            4: begin
               if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                  tens_char = b;
                  match_idx = 5;
               end else begin
                  match_idx = 0;
               end
            end
            5: begin
               match_idx = 0;
               // The tens digit may be stale when index 5 was reached in the other format.
               if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                  pos = (tens_char - CHAR_ZERO) * 8'd10 + (b - CHAR_ZERO);
                  hit = 1'b1;
               end
            end
            default: match_idx = 0;
         endcase
      end else begin
         case (match_idx)
            0: if (b == CHAR_SLASH) match_idx = 1;
            1: match_idx = (b == CHAR_ZERO + cfg_vtype) ? 2 : 0;
            3: match_idx = (b == CHAR_UP_P) ? 4 : 0;
            4: match_idx = (b == CHAR_LO_O) ? 5 : 0;
            5: match_idx = (b == CHAR_LO_S) ? 6 : 0;
            12: match_idx = (b == CHAR_LO_I) ? 13 : 0;
            13: match_idx = (b == CHAR_LO_S) ? 14 : 0;
            2, 6, 7, 8, 9, 10, 11, 14, 15: match_idx = match_idx + 1;
            16: begin
               match_idx = 0;
               if (b == CHAR_UP_A || b == CHAR_UP_B) begin
                  pos = b;
                  hit = 1'b1;
               end
            end
            default: match_idx = 0;
         endcase
      end
      return hit;
   endfunction

   // Results are checked before the new request is predicted: a result at this edge
   // always belongs to an earlier request.
   always @(posedge clock) begin : scoreboard
      logic [BYTE_W-1:0] pos;
      logic [BYTE_W-1:0] want;
      if (reset) begin
         match_idx  = '0;
         tens_char  = '0;
         cfg_vtype  = '0;
         cfg_format = FORMAT_CP;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_positions.size() == 0) begin
               $error("position_value: expected none, actual %0d", rsp_position_value);
               error_count++;
            end else begin
               want = expected_positions.pop_front();
               if (rsp_position_value !== want) begin
                  $error("position_value: expected %0d, actual %0d", want, rsp_position_value);
                  error_count++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_VALVE_TYPE:   cfg_vtype = csr_write_data;
               CSR_REPLY_FORMAT: cfg_format = csr_write_data[0];
            endcase
         end
         if (req_valid && !req_stall) begin
            if (predict_position(req_rx_byte, pos)) expected_positions.push_back(pos);
         end
      end
   end

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (rx_byte_queue.size() > 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_byte_queue.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 12);
               gap_left   = $urandom_range(1, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall: switches between free flow, heavy and light random stalls and a fixed
   // two-in-five pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         mode_left = 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 150);
         end else begin
            mode_left--;
         end
         stall_tick++;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= $urandom_range(0, 1);
            2:       rsp_stall <= ($urandom_range(0, 7) == 0);
            default: rsp_stall <= (stall_tick % 5) < 2;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (rx_byte_queue.size() != 0 || req_valid || expected_positions.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input int vtype, input logic fmt);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_VALVE_TYPE;
      csr_write_data   <= VTYPE_W'(vtype);
      @(posedge clock);
      csr_index        <= CSR_REPLY_FORMAT;
      csr_write_data   <= {{(VTYPE_W-1){1'b0}}, fmt};
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_text(input string s);
      foreach (s[i]) rx_byte_queue.push_back(s[i]);
   endtask

   // Queues one reply of the given format; now and then one byte is garbled or the
   // reply is cut short.
   task automatic queue_reply(input logic fmt, input logic [BYTE_W-1:0] addr);
      logic [BYTE_W-1:0] seq[$];
      int keep;
      int kind;
      seq.push_back(CHAR_SLASH);
      seq.push_back(addr);
      if (fmt == FORMAT_CP) begin
         seq.push_back(CHAR_UP_C);
         seq.push_back(CHAR_UP_P);
         repeat (2) seq.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end else begin
         seq.push_back(8'($urandom_range(0, 255)));
         seq.push_back(CHAR_UP_P);
         seq.push_back(CHAR_LO_O);
         seq.push_back(CHAR_LO_S);
         repeat (6) seq.push_back(8'($urandom_range(0, 255)));
         seq.push_back(CHAR_LO_I);
         seq.push_back(CHAR_LO_S);
         repeat (2) seq.push_back(8'($urandom_range(0, 255)));
         seq.push_back($urandom_range(0, 1) ? CHAR_UP_A : CHAR_UP_B);
      end
      keep = seq.size();
      kind = $urandom_range(0, 9);
      if (kind == 0) seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
      else if (kind == 1) keep = $urandom_range(1, seq.size() - 1);
      for (int i = 0; i < keep; i++) rx_byte_queue.push_back(seq[i]);
   endtask

   initial begin
      int   vtype;
      logic fmt;
      int   pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Both digit extremes, and a second slash that must not restart the match.
      set_config(0, FORMAT_CP);
      queue_text("/0CP00//0CP/0CP99");
      wait_drained();

      // Leave a position reply at index 5, then finish it as a CP reply with the
      // tens digit left over from before.
      set_config(9, FORMAT_POS);
      queue_text("/9xPo");
      wait_drained();
      set_config(9, FORMAT_CP);
      queue_text("7");
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin vtype = 0; fmt = FORMAT_CP;  end
            1: begin vtype = 9; fmt = FORMAT_POS; end
            2: begin vtype = 9; fmt = FORMAT_CP;  end
            3: begin vtype = 0; fmt = FORMAT_POS; end
            4: begin vtype = $urandom_range(0, 9); fmt = FORMAT_CP;  end
            5: begin vtype = $urandom_range(0, 9); fmt = FORMAT_POS; end
            default: begin vtype = $urandom_range(0, 9); fmt = $urandom_range(0, 1); end
         endcase
         set_config(vtype, fmt);
         while (rx_byte_queue.size() < PHASE_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) queue_reply(fmt, CHAR_ZERO + 8'(vtype));
            else if (pick < 72) queue_reply(!fmt, CHAR_ZERO + 8'(vtype));
            else if (pick < 82) queue_reply(fmt, 8'($urandom_range(0, 255)));
            else repeat ($urandom_range(1, 4)) rx_byte_queue.push_back(8'($urandom_range(0, 255)));
         end
         wait_drained();
      end

      if (error_count == 0 && expected_positions.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
